/* design/mka_pkg.sv */
// ----------------------------------------------------------------------------
// mka_pkg: shared types and constants of the mouse keys accelerator
// Operation and key codes, register indexes and reset values, and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package mka_pkg;

	localparam int CFG_COUNT = 8;
	localparam int CFG_IDX_W = 3;

	// operation codes of an input item
	localparam logic [2:0] FUNC_PRESS   = 3'd0;
	localparam logic [2:0] FUNC_RELEASE = 3'd1;
	localparam logic [2:0] FUNC_TICK    = 3'd2;
	localparam logic [2:0] FUNC_SEND    = 3'd3;
	localparam logic [2:0] FUNC_CLEAR   = 3'd4;

	// key codes
	localparam logic [4:0] KEY_UP       = 5'd0;
	localparam logic [4:0] KEY_DOWN     = 5'd1;
	localparam logic [4:0] KEY_LEFT     = 5'd2;
	localparam logic [4:0] KEY_RIGHT    = 5'd3;
	localparam logic [4:0] KEY_WH_UP    = 5'd4;
	localparam logic [4:0] KEY_WH_DOWN  = 5'd5;
	localparam logic [4:0] KEY_WH_LEFT  = 5'd6;
	localparam logic [4:0] KEY_WH_RIGHT = 5'd7;
	localparam logic [4:0] KEY_ACCEL0   = 5'd16;
	localparam logic [4:0] KEY_ACCEL1   = 5'd17;
	localparam logic [4:0] KEY_ACCEL2   = 5'd18;

	// register indexes
	localparam logic [2:0] REG_CUR_DELAY = 3'd0;
	localparam logic [2:0] REG_CUR_INTV  = 3'd1;
	localparam logic [2:0] REG_CUR_MAX   = 3'd2;
	localparam logic [2:0] REG_CUR_RAMP  = 3'd3;
	localparam logic [2:0] REG_WHL_DELAY = 3'd4;
	localparam logic [2:0] REG_WHL_INTV  = 3'd5;
	localparam logic [2:0] REG_WHL_MAX   = 3'd6;
	localparam logic [2:0] REG_WHL_RAMP  = 3'd7;

	localparam logic [7:0] CFG_RESET [CFG_COUNT] = '{
		8'd1, 8'd16, 8'd7, 8'd60, 8'd1, 8'd80, 8'd8, 8'd40
	};

	// diagonal scale 181/256 with rounding
	localparam logic [14:0] DIAG_MUL   = 15'd181;
	localparam logic [14:0] DIAG_ROUND = 15'd128;

	// delay registers count in units of ten milliseconds
	localparam logic [15:0] DELAY_UNIT = 16'd10;

	localparam logic [7:0] REPEAT_MAX = 8'hFF;

	typedef struct packed {
		logic load_item;
		logic unit_start;
		logic unit_wheel;
		logic apply_press;
		logic apply_event;
		logic inc_cur;
		logic inc_whl;
		logic set_cur;
		logic set_whl;
		logic finish;
	} mka_cmd_t;

	typedef struct packed {
		logic [2:0] func;
		logic       key_dir;
		logic       key_wheel;
		logic       cur_due;
		logic       whl_due;
		logic       unit_done;
		logic       out_free;
	} mka_status_t;

endpackage

/* design/mka_in_if.sv */
// ----------------------------------------------------------------------------
// mka_in_if: input item channel
// Valid/ready channel that carries one key event, tick, send or clear.
// ----------------------------------------------------------------------------
interface mka_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  func;
	logic [4:0]  key;
	logic [15:0] now_ms;

	modport source (output valid, func, key, now_ms, input ready);
	modport sink (input valid, func, key, now_ms, output ready);
endinterface

/* design/mka_out_if.sv */
// ----------------------------------------------------------------------------
// mka_out_if: result channel
// Valid/ready channel that carries one mouse report result.
// ----------------------------------------------------------------------------
interface mka_out_if;
	logic              valid;
	logic              ready;
	logic              report_sent;
	logic [7:0]        buttons;
	logic signed [7:0] move_x;
	logic signed [7:0] move_y;
	logic signed [7:0] wheel_v;
	logic signed [7:0] wheel_h;

	modport source (output valid, report_sent, buttons, move_x, move_y, wheel_v, wheel_h,
		input ready);
	modport sink (input valid, report_sent, buttons, move_x, move_y, wheel_v, wheel_h,
		output ready);
endinterface

/* design/mka_unit.sv */
// ----------------------------------------------------------------------------
// mka_unit: step size calculator
// Multiplies base by max speed, scales by accel keys or ramps by repeat count
// through a serial restoring divider, then clamps the step to 1..limit.
// ----------------------------------------------------------------------------
module mka_unit
	import mka_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [6:0] base,
	input  logic [7:0] speed_mul,
	input  logic [7:0] ramp,
	input  logic [7:0] reps,
	input  logic [2:0] accel,
	input  logic [6:0] limit,
	output logic       done,
	output logic [6:0] unit
);

	localparam int PROD_W = 15;
	localparam int NUM_W  = 23;
	localparam logic [4:0] DIV_LAST = 5'(NUM_W - 1);

	typedef enum logic [2:0] {U_IDLE, U_MUL, U_SEL, U_DIV, U_CLAMP} ustate_t;

	ustate_t            state_q;
	logic               done_q;
	logic [6:0]         base_q;
	logic [7:0]         maxsp_q;
	logic [7:0]         ramp_q;
	logic [7:0]         reps_q;
	logic [2:0]         accel_q;
	logic [6:0]         limit_q;
	logic [PROD_W-1:0]  prod_q;
	logic [NUM_W-1:0]   num_q;
	logic [7:0]         rem_q;
	logic [4:0]         cnt_q;
	logic [PROD_W-1:0]  val_q;
	logic [6:0]         unit_q;

	logic [8:0] trial;
	logic       fits;
	logic [8:0] diff;

	// one restoring divide step
	always_comb begin
		trial = {rem_q, num_q[NUM_W-1]};
		fits  = trial >= {1'b0, ramp_q};
		diff  = trial - {1'b0, ramp_q};
	end

	// sequence multiply, select, divide and clamp
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= U_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				U_IDLE: begin
					if (start) begin
						base_q  <= base;
						maxsp_q <= speed_mul;
						ramp_q  <= ramp;
						reps_q  <= reps;
						accel_q <= accel;
						limit_q <= limit;
						state_q <= U_MUL;
					end
				end
				U_MUL: begin
					prod_q  <= PROD_W'(base_q) * PROD_W'(maxsp_q);
					state_q <= U_SEL;
				end
				U_SEL: begin
					state_q <= U_CLAMP;
					priority if (accel_q[0]) begin
						val_q <= prod_q >> 2;
					end else if (accel_q[1]) begin
						val_q <= prod_q >> 1;
					end else if (accel_q[2]) begin
						val_q <= prod_q;
					end else if (reps_q == 8'd0) begin
						val_q <= PROD_W'(base_q);
					end else if (reps_q >= ramp_q) begin
						val_q <= prod_q;
					end else begin
						num_q   <= NUM_W'(prod_q) * NUM_W'(reps_q);
						rem_q   <= 8'd0;
						cnt_q   <= DIV_LAST;
						state_q <= U_DIV;
					end
				end
				U_DIV: begin
					rem_q <= fits ? diff[7:0] : trial[7:0];
					num_q <= {num_q[NUM_W-2:0], fits};
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == 5'd0) begin
						val_q   <= {num_q[PROD_W-2:0], fits};
						state_q <= U_CLAMP;
					end
				end
				U_CLAMP: begin
					priority if (val_q > PROD_W'(limit_q)) begin
						unit_q <= limit_q;
					end else if (val_q == '0) begin
						unit_q <= 7'd1;
					end else begin
						unit_q <= val_q[6:0];
					end
					done_q  <= 1'b1;
					state_q <= U_IDLE;
				end
				default: state_q <= U_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign unit = unit_q;

	// a finished step is never zero
	a_unit_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> unit_q != 7'd0)
		else $error("step size is zero");

	// a division runs only on a nonzero divisor
	a_div_ramp: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == U_DIV |-> ramp_q != 8'd0)
		else $error("divide by zero ramp");

	// done follows the clamp state only
	a_done_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q) == U_CLAMP)
		else $error("done without clamp");

endmodule

/* design/mka_ctrl.sv */
// ----------------------------------------------------------------------------
// mka_ctrl: controller of the mouse keys accelerator
// Steps each accepted item through dispatch, step size requests, the
// cursor and wheel repeat checks and the result transfer.
// ----------------------------------------------------------------------------
module mka_ctrl
	import mka_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  mka_status_t status,
	output mka_cmd_t    cmd
);

	typedef enum logic [3:0] {
		S_IDLE, S_DISPATCH, S_PRESS_WAIT, S_TICK_CUR, S_CUR_START, S_CUR_WAIT,
		S_TICK_WHL, S_WHL_START, S_WHL_WAIT, S_FINISH
	} state_t;

	state_t state_q;

	// advance the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid) state_q <= S_DISPATCH;
				S_DISPATCH: begin
					if (status.func == FUNC_PRESS && status.key_dir) begin
						state_q <= S_PRESS_WAIT;
					end else if (status.func == FUNC_TICK) begin
						state_q <= S_TICK_CUR;
					end else begin
						state_q <= S_FINISH;
					end
				end
				S_PRESS_WAIT: if (status.unit_done) state_q <= S_FINISH;
				S_TICK_CUR: state_q <= status.cur_due ? S_CUR_START : S_TICK_WHL;
				S_CUR_START: state_q <= S_CUR_WAIT;
				S_CUR_WAIT: if (status.unit_done) state_q <= S_TICK_WHL;
				S_TICK_WHL: state_q <= status.whl_due ? S_WHL_START : S_FINISH;
				S_WHL_START: state_q <= S_WHL_WAIT;
				S_WHL_WAIT: if (status.unit_done) state_q <= S_FINISH;
				S_FINISH: if (status.out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// decode commands
	always_comb begin
		cmd      = '0;
		in_ready = state_q == S_IDLE;
		unique case (state_q)
			S_IDLE: cmd.load_item = in_valid;
			S_DISPATCH: begin
				if (status.func == FUNC_PRESS && status.key_dir) begin
					cmd.unit_start = 1'b1;
					cmd.unit_wheel = status.key_wheel;
				end else if (status.func != FUNC_TICK) begin
					cmd.apply_event = 1'b1;
				end
			end
			S_PRESS_WAIT: cmd.apply_press = status.unit_done;
			S_TICK_CUR: cmd.inc_cur = status.cur_due;
			S_CUR_START: cmd.unit_start = 1'b1;
			S_CUR_WAIT: cmd.set_cur = status.unit_done;
			S_TICK_WHL: cmd.inc_whl = status.whl_due;
			S_WHL_START: begin
				cmd.unit_start = 1'b1;
				cmd.unit_wheel = 1'b1;
			end
			S_WHL_WAIT: cmd.set_whl = status.unit_done;
			S_FINISH: cmd.finish = status.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

/* design/mka_datapath.sv */
// ----------------------------------------------------------------------------
// mka_datapath: state and arithmetic of the mouse keys accelerator
// Holds the registers, held keys, repeat counters and send times, runs the
// step size unit and builds the result register.
// ----------------------------------------------------------------------------
module mka_datapath
	import mka_pkg::*;
#(
	parameter int MOVE_DELTA   = 8,
	parameter int MOVE_LIMIT   = 127,
	parameter int WHEEL_STEP   = 1,
	parameter int WHEEL_LIMIT  = 127,
	parameter int BUTTON_COUNT = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [7:0]           cfg_wdata,
	input  logic [2:0]           func,
	input  logic [4:0]           key,
	input  logic [15:0]          now_ms,
	input  mka_cmd_t             cmd,
	output mka_status_t          status,
	input  logic                 out_ready,
	output logic                 out_valid,
	output logic                 report_sent,
	output logic [7:0]           buttons,
	output logic signed [7:0]    move_x,
	output logic signed [7:0]    move_y,
	output logic signed [7:0]    wheel_v,
	output logic signed [7:0]    wheel_h
);

	logic [7:0]        cfg_q [CFG_COUNT];
	logic [2:0]        func_q;
	logic [4:0]        key_q;
	logic [15:0]       now_q;
	logic [7:0]        btn_q;
	logic signed [7:0] hx_q, hy_q, hv_q, hh_q;
	logic [2:0]        accel_q;
	logic [7:0]        crep_q, wrep_q;
	logic [15:0]       lct_q, lwt_q;
	logic signed [7:0] rx_q, ry_q, rv_q, rh_q;
	logic              out_valid_q;
	logic              sent_q;
	logic [7:0]        obtn_q;
	logic signed [7:0] ox_q, oy_q, ov_q, oh_q;

	logic       u_done;
	logic [6:0] u_val;

	function automatic logic signed [7:0] signed_mag(input logic [6:0] m, input logic neg);
		logic signed [7:0] p;
		p = $signed({1'b0, m});
		return neg ? -p : p;
	endfunction

	// step size unit, shared by cursor and wheel
	mka_unit u_unit (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.unit_start),
		.base      (cmd.unit_wheel ? 7'(WHEEL_STEP) : 7'(MOVE_DELTA)),
		.speed_mul (cmd.unit_wheel ? cfg_q[REG_WHL_MAX] : cfg_q[REG_CUR_MAX]),
		.ramp      (cmd.unit_wheel ? cfg_q[REG_WHL_RAMP] : cfg_q[REG_CUR_RAMP]),
		.reps      (cmd.unit_wheel ? wrep_q : crep_q),
		.accel     (accel_q),
		.limit     (cmd.unit_wheel ? 7'(WHEEL_LIMIT) : 7'(MOVE_LIMIT)),
		.done      (u_done),
		.unit      (u_val)
	);

	// key decode
	logic       is_btn, is_accel;
	logic [2:0] accel_bit;
	logic [7:0] btn_bit;
	always_comb begin
		is_btn    = key_q[4:3] == 2'b01 && {1'b0, key_q[2:0]} < 4'(BUTTON_COUNT);
		is_accel  = key_q == KEY_ACCEL0 || key_q == KEY_ACCEL1 || key_q == KEY_ACCEL2;
		accel_bit = 3'b001 << key_q[1:0];
		btn_bit   = 8'b1 << key_q[2:0];
	end

	// repeat checks
	logic [15:0] cur_wait, whl_wait, cur_el, whl_el;
	logic        cur_held, whl_held;
	always_comb begin
		cur_held = hx_q != 8'sd0 || hy_q != 8'sd0;
		whl_held = hv_q != 8'sd0 || hh_q != 8'sd0;
		cur_wait = crep_q != 8'd0 ? {8'd0, cfg_q[REG_CUR_INTV]}
			: 16'(16'(cfg_q[REG_CUR_DELAY]) * DELAY_UNIT);
		whl_wait = wrep_q != 8'd0 ? {8'd0, cfg_q[REG_WHL_INTV]}
			: 16'(16'(cfg_q[REG_WHL_DELAY]) * DELAY_UNIT);
		cur_el   = now_q - lct_q;
		whl_el   = now_q - lwt_q;
	end

	// diagonal scaling of the finished step
	logic [14:0] diag_prod;
	logic [6:0]  diag_mag;
	always_comb begin
		diag_prod = 15'(u_val) * DIAG_MUL + DIAG_ROUND;
		diag_mag  = diag_prod[14:8];
	end

	// event update of held keys
	logic signed [7:0] ex, ey, ev, eh;
	logic [7:0]        ebtn;
	logic [2:0]        eacc;
	always_comb begin
		ex   = hx_q;
		ey   = hy_q;
		ev   = hv_q;
		eh   = hh_q;
		ebtn = btn_q;
		eacc = accel_q;
		if (func_q == FUNC_PRESS) begin
			if (is_accel) eacc = accel_q | accel_bit;
			else if (is_btn) ebtn = btn_q | btn_bit;
		end else if (func_q == FUNC_RELEASE) begin
			unique case (key_q)
				KEY_UP:       if (hy_q < 0) ey = 8'sd0;
				KEY_DOWN:     if (hy_q > 0) ey = 8'sd0;
				KEY_LEFT:     if (hx_q < 0) ex = 8'sd0;
				KEY_RIGHT:    if (hx_q > 0) ex = 8'sd0;
				KEY_WH_UP:    if (hv_q > 0) ev = 8'sd0;
				KEY_WH_DOWN:  if (hv_q < 0) ev = 8'sd0;
				KEY_WH_LEFT:  if (hh_q < 0) eh = 8'sd0;
				KEY_WH_RIGHT: if (hh_q > 0) eh = 8'sd0;
				default: begin
					if (is_accel) eacc = accel_q & ~accel_bit;
					else if (is_btn) ebtn = btn_q & ~btn_bit;
				end
			endcase
		end else if (func_q == FUNC_CLEAR) begin
			ex   = 8'sd0;
			ey   = 8'sd0;
			ev   = 8'sd0;
			eh   = 8'sd0;
			ebtn = 8'd0;
			eacc = 3'd0;
		end
	end

	// report selection at the end of an item
	logic              f_sent;
	logic signed [7:0] fx, fy, fv, fh;
	always_comb begin
		if (func_q == FUNC_SEND) begin
			fx = hx_q;
			fy = hy_q;
			fv = hv_q;
			fh = hh_q;
		end else begin
			fx = rx_q;
			fy = ry_q;
			fv = rv_q;
			fh = rh_q;
		end
		f_sent = func_q == FUNC_SEND || (func_q == FUNC_TICK &&
			(rx_q != 8'sd0 || ry_q != 8'sd0 || rv_q != 8'sd0 || rh_q != 8'sd0));
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CFG_COUNT; i++) cfg_q[i] <= CFG_RESET[i];
		end else if (cfg_we) begin
			cfg_q[cfg_idx] <= cfg_wdata;
		end
	end

	// item capture and tick results
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			func_q <= func;
			key_q  <= key;
			now_q  <= now_ms;
			rx_q   <= 8'sd0;
			ry_q   <= 8'sd0;
			rv_q   <= 8'sd0;
			rh_q   <= 8'sd0;
		end
		if (cmd.set_cur) begin
			if (hx_q != 8'sd0)
				rx_q <= signed_mag(hy_q != 8'sd0 ? diag_mag : u_val, hx_q < 0);
			if (hy_q != 8'sd0)
				ry_q <= signed_mag(hx_q != 8'sd0 ? diag_mag : u_val, hy_q < 0);
		end
		if (cmd.set_whl) begin
			if (hv_q != 8'sd0)
				rv_q <= signed_mag(hh_q != 8'sd0 ? diag_mag : u_val, hv_q < 0);
			if (hh_q != 8'sd0)
				rh_q <= signed_mag(hv_q != 8'sd0 ? diag_mag : u_val, hh_q < 0);
		end
	end

	// held keys, repeat counters and send times
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			btn_q   <= 8'd0;
			hx_q    <= 8'sd0;
			hy_q    <= 8'sd0;
			hv_q    <= 8'sd0;
			hh_q    <= 8'sd0;
			accel_q <= 3'd0;
			crep_q  <= 8'd0;
			wrep_q  <= 8'd0;
			lct_q   <= 16'd0;
			lwt_q   <= 16'd0;
		end else begin
			if (cmd.apply_event) begin
				btn_q   <= ebtn;
				hx_q    <= ex;
				hy_q    <= ey;
				hv_q    <= ev;
				hh_q    <= eh;
				accel_q <= eacc;
				if (func_q == FUNC_CLEAR ||
					(func_q == FUNC_RELEASE && ex == 8'sd0 && ey == 8'sd0))
					crep_q <= 8'd0;
				if (func_q == FUNC_CLEAR ||
					(func_q == FUNC_RELEASE && ev == 8'sd0 && eh == 8'sd0))
					wrep_q <= 8'd0;
			end
			if (cmd.apply_press) begin
				unique case (key_q[2:0])
					KEY_UP[2:0]:       hy_q <= signed_mag(u_val, 1'b1);
					KEY_DOWN[2:0]:     hy_q <= signed_mag(u_val, 1'b0);
					KEY_LEFT[2:0]:     hx_q <= signed_mag(u_val, 1'b1);
					KEY_RIGHT[2:0]:    hx_q <= signed_mag(u_val, 1'b0);
					KEY_WH_UP[2:0]:    hv_q <= signed_mag(u_val, 1'b0);
					KEY_WH_DOWN[2:0]:  hv_q <= signed_mag(u_val, 1'b1);
					KEY_WH_LEFT[2:0]:  hh_q <= signed_mag(u_val, 1'b1);
					KEY_WH_RIGHT[2:0]: hh_q <= signed_mag(u_val, 1'b0);
					default: hx_q <= hx_q;
				endcase
			end
			if (cmd.inc_cur && crep_q != REPEAT_MAX) crep_q <= crep_q + 8'd1;
			if (cmd.inc_whl && wrep_q != REPEAT_MAX) wrep_q <= wrep_q + 8'd1;
			if (cmd.finish && f_sent) begin
				if (fx != 8'sd0 || fy != 8'sd0) lct_q <= now_q;
				if (fv != 8'sd0 || fh != 8'sd0) lwt_q <= now_q;
			end
		end
	end

	// result register: hold until transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			sent_q <= f_sent;
			obtn_q <= f_sent ? btn_q : 8'd0;
			ox_q   <= f_sent ? fx : 8'sd0;
			oy_q   <= f_sent ? fy : 8'sd0;
			ov_q   <= f_sent ? fv : 8'sd0;
			oh_q   <= f_sent ? fh : 8'sd0;
		end
	end

	always_comb begin
		status.func      = func_q;
		status.key_dir   = key_q[4:3] == 2'b00;
		status.key_wheel = key_q[2];
		status.cur_due   = cur_held && cur_el > cur_wait;
		status.whl_due   = whl_held && whl_el > whl_wait;
		status.unit_done = u_done;
		status.out_free  = !out_valid_q || out_ready;
	end

	assign out_valid   = out_valid_q;
	assign report_sent = sent_q;
	assign buttons     = obtn_q;
	assign move_x      = ox_q;
	assign move_y      = oy_q;
	assign wheel_v     = ov_q;
	assign wheel_h     = oh_q;

	// a new result never overwrites one not yet taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !out_valid_q || out_ready)
		else $error("result overwritten");

	// held directions stay within the symmetric range
	a_held_range: assert property (@(posedge clk) disable iff (!arst_n)
		hx_q != -8'sd128 && hy_q != -8'sd128 && hv_q != -8'sd128 && hh_q != -8'sd128)
		else $error("held direction out of range");

	// a result without a report carries no motion
	a_quiet_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !sent_q |-> ox_q == 8'sd0 && oy_q == 8'sd0 && obtn_q == 8'd0)
		else $error("motion in an unsent result");

endmodule

/* design/mouse_keys_accelerator_unit.sv */
// ----------------------------------------------------------------------------
// mouse_keys_accelerator_unit: mouse keys accelerator top level
// Turns key events, millisecond ticks, send and clear requests into mouse
// reports with linear speed ramping and diagonal scaling.
//
//   channel   kind          fields
//   in_ch     valid/ready   func, key, now_ms
//   out_ch    valid/ready   report_sent, buttons, move_x, move_y, wheel_v, wheel_h
//   cfg       write only    cfg_we, cfg_idx, cfg_wdata
//
// One item at a time. Release, clear and send go through dispatch and finish; a press
// of a direction also waits for the step size from the shared step unit and its
// 23-step serial divider (a tick stepping both cursor and wheel runs it twice).
// Reset is asynchronous and restores the register defaults. The next item is
// taken while a result waits; a stalled result holds the controller at its end.
// ----------------------------------------------------------------------------
module mouse_keys_accelerator_unit
	import mka_pkg::*;
#(
	parameter int MOVE_DELTA   = 8,
	parameter int MOVE_LIMIT   = 127,
	parameter int WHEEL_STEP   = 1,
	parameter int WHEEL_LIMIT  = 127,
	parameter int BUTTON_COUNT = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	mka_in_if.sink               in_ch,
	mka_out_if.source            out_ch,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [7:0]           cfg_wdata
);

	mka_cmd_t    cmd;
	mka_status_t status;

	// controller
	mka_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.status   (status),
		.cmd      (cmd)
	);

	// datapath
	mka_datapath #(
		.MOVE_DELTA   (MOVE_DELTA),
		.MOVE_LIMIT   (MOVE_LIMIT),
		.WHEEL_STEP   (WHEEL_STEP),
		.WHEEL_LIMIT  (WHEEL_LIMIT),
		.BUTTON_COUNT (BUTTON_COUNT)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_idx     (cfg_idx),
		.cfg_wdata   (cfg_wdata),
		.func        (in_ch.func),
		.key         (in_ch.key),
		.now_ms      (in_ch.now_ms),
		.cmd         (cmd),
		.status      (status),
		.out_ready   (out_ch.ready),
		.out_valid   (out_ch.valid),
		.report_sent (out_ch.report_sent),
		.buttons     (out_ch.buttons),
		.move_x      (out_ch.move_x),
		.move_y      (out_ch.move_y),
		.wheel_v     (out_ch.wheel_v),
		.wheel_h     (out_ch.wheel_h)
	);

endmodule
